>>> rtl/core/dews_pkg.sv
package dews_pkg;

    localparam int NUM_WHEELS = 2;
    localparam int WHEEL_LEFT = 0;
    localparam int WHEEL_RIGHT = 1;

    // Quotient bits produced by the divider, one per cycle
    localparam int QUOT_BITS = 32;
    localparam int COUNT_BITS = $clog2(QUOT_BITS);

    // 2*pi*1e6*2^16 rounded, split at bit 32 for the partial products
    localparam logic [31:0] SPEED_K_LO = 32'd3752939171;
    localparam logic [6:0] SPEED_K_HI = 7'd95;

    // Configuration register indexes
    localparam logic [1:0] CFG_TICKS_PER_REV = 2'd0;
    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_GLITCH_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_RND,
        ST_FIN
    } dews_state_t;

    typedef struct packed {
        logic load_item;
        logic mul;
        logic sum;
        logic div_step;
        logic rnd;
        logic load_out;
    } dews_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } dews_status_t;

endpackage

>>> rtl/core/dual_encoder_wheel_speed.sv
// Wheel speed estimator for a pair of incremental encoders.
//
// Input channel (in_valid / in_ready): one word per encoder sample, carrying
// both absolute counts, the driver status byte and a microsecond timestamp.
// Output channel (out_valid / out_ready): one word per sample that has a
// valid speed: left and right speed in signed Q16.16 rad/s plus the stamp.
// A sample gives no word when it is the first after reset, when time did not
// advance past the minimum interval, or when time went backwards.
//
// Sequence: a silent sample is accepted in the idle state, which the block does
// not leave. A sample with a result goes from acceptance to out_valid through
// a multiply step, a sum step, the shared-divisor restoring divider (one
// quotient bit per cycle for both wheels), a rounding and an output step.
// The next sample can be accepted in the cycle in which out_valid rises;
// no new sample is accepted while one with a result is still in progress.
//
// The output register parts the two sides: a stalled receiver does not stop
// the next sample from being accepted and processed; the block only holds in
// its final step until the pending word is taken.
//
// Reset clears the previous counts and time and arms the first-sample load;
// configuration registers return to 360 ticks/rev, 100 us, 1000000 ticks.
module dual_encoder_wheel_speed
    import dews_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  left_count,
    input  logic signed [31:0]  right_count,
    input  logic [7:0]          driver_status,
    input  logic [47:0]         sample_time_us,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  left_speed,
    output logic signed [31:0]  right_speed,
    output logic [47:0]         stamp_us
);

    logic [15:0] ticks_per_rev_reg;
    logic [19:0] min_interval_reg;
    logic [30:0] glitch_limit_reg;

    dews_cmd_t    cmd;
    dews_status_t status;

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_rev_reg <= 16'd360;
            min_interval_reg <= 20'd100;
            glitch_limit_reg <= 31'd1000000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_REV: ticks_per_rev_reg <= cfg_data[15:0];
                CFG_MIN_INTERVAL:  min_interval_reg <= cfg_data[19:0];
                CFG_GLITCH_LIMIT:  glitch_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: accepts a word, steps the datapath, loads the output.
    dews_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: tracking state, multiplier, divider and output register.
    dews_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .left_count      (left_count),
        .right_count     (right_count),
        .driver_status   (driver_status),
        .sample_time_us  (sample_time_us),
        .ticks_per_rev   (ticks_per_rev_reg),
        .min_interval_us (min_interval_reg),
        .glitch_limit    (glitch_limit_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_speed      (left_speed),
        .right_speed     (right_speed),
        .stamp_us        (stamp_us)
    );

endmodule

>>> rtl/core/dews_ctrl.sv
module dews_ctrl
    import dews_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  dews_status_t status,
    output dews_cmd_t    cmd
);

    dews_state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(QUOT_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.emit)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == COUNT_LAST)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cmd.rnd = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output loaded while still occupied");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && count_reg != COUNT_LAST)
        |=> (state_reg == ST_DIV && count_reg == $past(count_reg) + 1'b1))
        else $error("divider step count broken");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_item && !status.emit) |=> state_reg == ST_IDLE)
        else $error("silent word started a division");

    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_item && status.emit) |=> state_reg == ST_MUL)
        else $error("emitting word did not start a division");

endmodule

>>> rtl/core/dews_dp.sv
module dews_dp
    import dews_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dews_cmd_t           cmd,
    output dews_status_t        status,
    input  logic signed [31:0]  left_count,
    input  logic signed [31:0]  right_count,
    input  logic [7:0]          driver_status,
    input  logic [47:0]         sample_time_us,
    input  logic [15:0]         ticks_per_rev,
    input  logic [19:0]         min_interval_us,
    input  logic [30:0]         glitch_limit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  left_speed,
    output logic signed [31:0]  right_speed,
    output logic [47:0]         stamp_us
);

    // tracking state
    logic [31:0] prev_reg [NUM_WHEELS];
    logic [47:0] prev_time_reg;
    logic        first_reg;

    // per-item working registers
    logic [31:0] mag_reg [NUM_WHEELS];
    logic        neg_reg [NUM_WHEELS];
    logic [47:0] dt_reg;
    logic [47:0] stamp_reg;
    logic [63:0] den_reg;
    logic [63:0] plo_reg [NUM_WHEELS];
    logic [38:0] phi_reg [NUM_WHEELS];
    logic [64:0] rem_reg [NUM_WHEELS];
    logic [31:0] low_reg [NUM_WHEELS];
    logic [31:0] quot_reg [NUM_WHEELS];
    logic        sat_reg [NUM_WHEELS];
    logic [32:0] qrnd_reg [NUM_WHEELS];

    // output register
    logic        out_valid_reg;
    logic [31:0] speed_reg [NUM_WHEELS];
    logic [47:0] stamp_out_reg;

    logic [31:0] count_in [NUM_WHEELS];
    logic [31:0] base [NUM_WHEELS];
    logic [31:0] delta [NUM_WHEELS];
    logic [31:0] dmag [NUM_WHEELS];
    logic        glitch;
    logic [47:0] dt;
    logic [15:0] tpr_eff;
    logic [70:0] num [NUM_WHEELS];
    logic [64:0] shifted [NUM_WHEELS];
    logic        ge [NUM_WHEELS];
    logic        rnd_up [NUM_WHEELS];
    logic [32:0] lim [NUM_WHEELS];
    logic [32:0] clamp [NUM_WHEELS];
    logic [31:0] speed [NUM_WHEELS];

    assign count_in[WHEEL_LEFT] = left_count;
    assign count_in[WHEEL_RIGHT] = right_count;
    assign dt = sample_time_us - prev_time_reg;
    assign tpr_eff = (ticks_per_rev == '0) ? 16'd1 : ticks_per_rev;

    always_comb
    begin
        glitch = 1'b0;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            // a zero status means the driver cleared its counters
            base[w] = (driver_status == 8'd0) ? 32'd0 : prev_reg[w];
            delta[w] = count_in[w] - base[w];
            dmag[w] = delta[w][31] ? (~delta[w] + 32'd1) : delta[w];
            if (dmag[w] > {1'b0, glitch_limit})
            begin
                glitch = 1'b1;
            end
        end
    end

    assign status.emit = !first_reg && (sample_time_us > prev_time_reg)
                         && (dt > {28'd0, min_interval_us});
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            num[w] = {7'd0, plo_reg[w]} + {phi_reg[w], 32'd0};
            shifted[w] = {rem_reg[w][63:0], low_reg[w][31]};
            ge[w] = shifted[w] >= {1'b0, den_reg};
            rnd_up[w] = {rem_reg[w][63:0], 1'b0} >= {1'b0, den_reg};
            lim[w] = neg_reg[w] ? 33'h080000000 : 33'h07FFFFFFF;
            clamp[w] = (sat_reg[w] || qrnd_reg[w] > lim[w]) ? lim[w] : qrnd_reg[w];
            speed[w] = neg_reg[w] ? (~clamp[w][31:0] + 32'd1) : clamp[w][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                prev_reg[w] <= '0;
            end
            prev_time_reg <= '0;
            first_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                prev_time_reg <= sample_time_us;
                first_reg <= 1'b0;
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    if (first_reg || !glitch)
                    begin
                        prev_reg[w] <= count_in[w];
                    end
                    else
                    begin
                        prev_reg[w] <= base[w];
                    end
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            dt_reg <= dt;
            stamp_reg <= sample_time_us;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                mag_reg[w] <= glitch ? 32'd0 : dmag[w];
                neg_reg[w] <= glitch ? 1'b0 : delta[w][31];
            end
        end
        if (cmd.mul)
        begin
            den_reg <= tpr_eff * dt_reg;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                plo_reg[w] <= mag_reg[w] * SPEED_K_LO;
                phi_reg[w] <= mag_reg[w] * SPEED_K_HI;
            end
        end
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (cmd.sum)
            begin
                // quotient at or above 2^32 saturates anyway
                rem_reg[w] <= {26'd0, num[w][70:32]};
                low_reg[w] <= num[w][31:0];
                sat_reg[w] <= {25'd0, num[w][70:32]} >= den_reg;
            end
            if (cmd.div_step)
            begin
                rem_reg[w] <= ge[w] ? (shifted[w] - {1'b0, den_reg}) : shifted[w];
                low_reg[w] <= {low_reg[w][30:0], 1'b0};
                quot_reg[w] <= {quot_reg[w][30:0], ge[w]};
            end
            if (cmd.rnd)
            begin
                qrnd_reg[w] <= {1'b0, quot_reg[w]} + {32'd0, rnd_up[w]};
            end
            if (cmd.load_out)
            begin
                speed_reg[w] <= speed[w];
            end
        end
        if (cmd.load_out)
        begin
            stamp_out_reg <= stamp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_speed = speed_reg[WHEEL_LEFT];
    assign right_speed = speed_reg[WHEEL_RIGHT];
    assign stamp_us = stamp_out_reg;

endmodule

>>> tb/tb_dual_encoder_wheel_speed.sv
`timescale 1ns / 100ps

module tb_dual_encoder_wheel_speed;

    import dews_pkg::*;

    // 2*pi*1e6*2^16 rounded: turns ticks per microsecond into Q16.16 rad/s
    localparam logic [63:0] RAD_SCALE = 64'd411774832291;
    // Cycles to let the block settle after the last expected word
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_GUARD = 100000;
    // Long output stall: fills the output register and backs up the input
    localparam int LONG_STALL = 3000;
    localparam int STALL_AFTER = 450;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic [7:0]         status;
        logic [47:0]        stamp;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic [47:0]        stamp;
    } speed_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = CFG_TICKS_PER_REV;
    logic [30:0]        cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] left_count = '0;
    logic signed [31:0] right_count = '0;
    logic [7:0]         driver_status = '0;
    logic [47:0]        sample_time_us = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic [47:0]        stamp_us;

    dual_encoder_wheel_speed DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_count     (left_count),
        .right_count    (right_count),
        .driver_status  (driver_status),
        .sample_time_us (sample_time_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .stamp_us       (stamp_us)
    );

    always #10 clk = ~clk;

    // Samples waiting to be offered, and speed words the block still owes
    sample_t     samples_to_send[$];
    speed_word_t speeds_due[$];

    int samples_in = 0;
    int words_out = 0;
    int fail_count = 0;
    int settings_written = 0;

    // Idle percentages of the two sides, changed between phases
    int send_idle_pct = 36;
    int recv_idle_pct = 83;

    // Predictor copy of the registers, at their reset values
    logic [15:0] cfg_tpr = 16'd360;
    logic [19:0] cfg_min_gap = 20'd100;
    logic [30:0] cfg_glitch = 31'd1000000;

    // Predictor copy of the block state
    logic [31:0] last_left = '0;
    logic [31:0] last_right = '0;
    logic [47:0] last_stamp = '0;
    bit          awaiting_first = 1'b1;

    // Generator cursor: counts and time of the well-formed stream
    logic [31:0] gen_left = '0;
    logic [31:0] gen_right = '0;
    logic [47:0] gen_time = '0;

    // Magnitude of a 32-bit two's complement tick delta; -2^31 gives 2^31
    function automatic logic [31:0] tick_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Rounded delta * RAD_SCALE / den, half away from zero, saturated to 32 bits
    function automatic logic [31:0] wheel_rate(input logic [31:0] delta,
                                               input logic [63:0] den);
        logic [127:0] num;
        logic [127:0] div;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] lim;
        num = tick_mag(delta);
        num = num * RAD_SCALE;
        div = den;
        quo = num / div;
        rem = num % div;
        if ((rem << 1) >= div)
            quo = quo + 128'd1;
        lim = delta[31] ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim)
            quo = lim;
        return delta[31] ? (32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    // Advance the predicted state by one sample; returns 1 when a word is due
    function automatic bit predict_word(input sample_t s, output speed_word_t w);
        logic [31:0] dl;
        logic [31:0] dr;
        logic [47:0] dt;
        logic [63:0] den;
        logic [15:0] tpr;
        bit          emit;
        w = '0;
        // status zero: the driver cleared its encoders
        if (s.status == 8'd0) begin
            last_left = '0;
            last_right = '0;
        end
        // the very first sample only loads the history
        if (awaiting_first) begin
            last_left = s.left;
            last_right = s.right;
            last_stamp = s.stamp;
            awaiting_first = 1'b0;
            return 1'b0;
        end
        dl = s.left - last_left;
        dr = s.right - last_right;
        // glitch on either wheel: zero both deltas and keep the old counts
        if (tick_mag(dl) > {1'b0, cfg_glitch} || tick_mag(dr) > {1'b0, cfg_glitch}) begin
            dl = '0;
            dr = '0;
        end
        else begin
            last_left = s.left;
            last_right = s.right;
        end
        // backwards, equal or too short an interval gives no word
        emit = (s.stamp > last_stamp) && ((s.stamp - last_stamp) > {28'd0, cfg_min_gap});
        dt = s.stamp - last_stamp;
        last_stamp = s.stamp;
        if (!emit)
            return 1'b0;
        tpr = (cfg_tpr == 16'd0) ? 16'd1 : cfg_tpr;
        den = {48'd0, tpr} * {16'd0, dt};
        w.left = wheel_rate(dl, den);
        w.right = wheel_rate(dr, den);
        w.stamp = s.stamp;
        return 1'b1;
    endfunction

    // Random tick step that stays within the glitch limit, mostly small
    function automatic logic [31:0] tick_step();
        logic [31:0] lim;
        logic [31:0] m;
        lim = {1'b0, cfg_glitch};
        case ($urandom_range(3, 0))
            0: if (lim > 32'd100) lim = 32'd100;
            1: if (lim > 32'd20000) lim = 32'd20000;
            default: ;
        endcase
        m = $urandom % (lim + 32'd1);
        return $urandom_range(1, 0) ? (~m + 32'd1) : m;
    endfunction

    task automatic queue_sample(input logic [31:0] l, input logic [31:0] r,
                                input logic [7:0] st, input logic [47:0] t);
        sample_t s;
        s.left = l;
        s.right = r;
        s.status = st;
        s.stamp = t;
        samples_to_send.push_back(s);
        gen_time = t;
    endtask

    // Mostly well-formed motion at random speeds; the rest is noise:
    // wild counts, encoder resets, time jumps, short gaps and glitches
    task automatic queue_random(input int count);
        int          kind;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [47:0] gap;
        logic [7:0]  st;
        repeat (count) begin
            kind = $urandom_range(99, 0);
            st = $urandom_range(255, 1);
            gap = {28'd0, cfg_min_gap} + $urandom_range(2000, 1);
            if (kind < 80) begin
                gen_left = gen_left + tick_step();
                gen_right = gen_right + tick_step();
                queue_sample(gen_left, gen_right, st, gen_time + gap);
            end
            else begin
                case (kind % 5)
                    0: queue_sample($urandom, $urandom, st, gen_time + gap);
                    1: begin
                        gen_left = tick_step();
                        gen_right = tick_step();
                        queue_sample(gen_left, gen_right, 8'd0, gen_time + gap);
                    end
                    2: begin
                        hi = $urandom;
                        lo = $urandom;
                        queue_sample(gen_left, gen_right, st, {hi[15:0], lo});
                    end
                    3: begin
                        gen_left = gen_left + tick_step();
                        gen_right = gen_right + tick_step();
                        queue_sample(gen_left, gen_right, st,
                                     gen_time + $urandom_range(cfg_min_gap, 0));
                    end
                    default: queue_sample(gen_left + {1'b0, cfg_glitch} + 32'd1
                                          + ($urandom % 1000), gen_right, st,
                                          gen_time + gap);
                endcase
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_TICKS_PER_REV: cfg_tpr = val[15:0];
            CFG_MIN_INTERVAL: cfg_min_gap = val[19:0];
            CFG_GLITCH_LIMIT: cfg_glitch = val;
            default: ;
        endcase
    endtask

    // Write all three registers back to back, then drop the enable
    task automatic load_setting(input logic [30:0] tpr, input logic [30:0] gap,
                                input logic [30:0] glitch);
        write_reg(CFG_TICKS_PER_REV, tpr);
        write_reg(CFG_MIN_INTERVAL, gap);
        write_reg(CFG_GLITCH_LIMIT, glitch);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_written++;
        // hold new samples off the clock edge
        @(negedge clk);
    endtask

    // Wait until every sample is taken and every word is back, then settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        while ((samples_to_send.size() != 0 || in_valid || speeds_due.size() != 0)
               && guard < DRAIN_GUARD) begin
            @(negedge clk);
            guard++;
        end
        if (guard >= DRAIN_GUARD) begin
            $error("drain timed out: %0d samples queued, %0d speed words owed",
                   samples_to_send.size(), speeds_due.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: predict on acceptance, then offer the next sample or idle
    always @(posedge clk) begin : drive_samples
        sample_t     taken;
        sample_t     nxt;
        speed_word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                taken.left = left_count;
                taken.right = right_count;
                taken.status = driver_status;
                taken.stamp = sample_time_us;
                samples_in <= samples_in + 1;
                if (predict_word(taken, w))
                    speeds_due.push_back(w);
            end
            // payload may only change once the current word is gone
            if (!in_valid || in_ready) begin
                if (samples_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    nxt = samples_to_send.pop_front();
                    in_valid <= 1'b1;
                    left_count <= nxt.left;
                    right_count <= nxt.right;
                    driver_status <= nxt.status;
                    sample_time_us <= nxt.stamp;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, plus one long stall once traffic is flowing
    int stall_left = 0;
    bit stall_done = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!stall_done && samples_in >= STALL_AFTER) begin
            out_ready <= 1'b0;
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
        end
        else begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor: every accepted word must match the oldest owed word
    always @(posedge clk) begin : check_speeds
        speed_word_t want;
        if (rst_n && out_valid && out_ready) begin
            words_out <= words_out + 1;
            if (speeds_due.size() == 0) begin
                $error("speed word with nothing owed: left %0d right %0d stamp %0d",
                       left_speed, right_speed, stamp_us);
                fail_count++;
            end
            else begin
                want = speeds_due.pop_front();
                if (left_speed !== want.left) begin
                    $error("left_speed: expected %0d, got %0d", want.left, left_speed);
                    fail_count++;
                end
                if (right_speed !== want.right) begin
                    $error("right_speed: expected %0d, got %0d", want.right, right_speed);
                    fail_count++;
                end
                if (stamp_us !== want.stamp) begin
                    $error("stamp_us: expected %0d, got %0d", want.stamp, stamp_us);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: first sample, intervals, encoder reset, glitches
        queue_sample(32'd100, -32'sd100, 8'd1, 48'd1000);
        queue_sample(32'd200, -32'sd300, 8'd1, 48'd2000);
        // interval equal to the minimum: silent
        queue_sample(32'd200, -32'sd300, 8'd2, 48'd2100);
        queue_sample(32'd210, -32'sd290, 8'd255, 48'd2201);
        // encoder reset clears the history
        queue_sample(32'd5, -32'sd5, 8'd0, 48'd3000);
        // left glitch zeroes both wheels
        queue_sample(32'd2000005, -32'sd5, 8'd1, 48'd4000);
        // deltas at exactly the limit pass and saturate both ways
        queue_sample(32'd1000005, -32'sd1000005, 8'd1, 48'd4102);
        // time backwards, then time standing still
        queue_sample(32'd1000006, -32'sd1000005, 8'd1, 48'd4000);
        queue_sample(32'd1000007, -32'sd1000005, 8'd1, 48'd4000);
        // extreme counts right after an encoder reset
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 48'd5000);
        queue_sample(32'd1000, -32'sd1000, 8'd128, 48'd1005000);
        gen_left = 32'd1000;
        gen_right = -32'sd1000;
        queue_random(120);
        wait_idle();

        // Lowest ticks per rev, no minimum interval, widest glitch window
        load_setting(31'd1, 31'd0, 31'h7FFF_FFFF);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0001, 8'd0, gen_time + 48'd1);
        // a delta of -2^31 is a glitch whatever the limit
        queue_sample(32'hFFFF_FFFF, 32'h8000_0001, 8'd1, gen_time + 48'd1);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0001, 8'd1, gen_time);
        queue_sample(32'h7FFF_FFFE, 32'h8000_0002, 8'd1, gen_time + 48'd4096);
        gen_left = 32'h7FFF_FFFE;
        gen_right = 32'h8000_0002;
        queue_random(150);
        wait_idle();

        // Sender now idles more than the receiver
        send_idle_pct = 83;
        recv_idle_pct = 36;

        // Highest ticks per rev and a long minimum interval; span the full time range
        load_setting(31'd65535, 31'd1000000, 31'h7FFF_FFFF);
        queue_sample(32'd0, 32'd0, 8'd0, 48'd0);
        queue_sample(32'h1234_5678, 32'hEDCB_A988, 8'd1, 48'hFFFF_FFFF_FFFF);
        queue_sample(32'd0, 32'd0, 8'd0, 48'd0);
        gen_left = '0;
        gen_right = '0;
        queue_random(150);
        wait_idle();

        // Zero ticks per rev acts as one
        load_setting(31'd0, 31'd50, 31'd5000);
        queue_sample(32'd1234, -32'sd4321, 8'd0, gen_time + 48'd51);
        queue_sample(32'd6234, -32'sd9320, 8'd1, gen_time + 48'd51);
        gen_left = 32'd6234;
        gen_right = -32'sd9320;
        queue_random(150);
        wait_idle();

        // Neither side idles from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Zero glitch limit: any movement counts as a glitch
        load_setting($urandom_range(65535, 1), $urandom_range(2000, 0), 31'd0);
        queue_random(160);
        wait_idle();

        load_setting($urandom_range(65535, 1), $urandom_range(5000, 0),
                     $urandom_range(32'h7FFF_FFFF, 0));
        queue_random(170);
        wait_idle();

        $display("%0d encoder samples sent, %0d speed words checked", samples_in, words_out);
        $display("reset registers plus %0d written settings, both idle mixes and a long stall",
                 settings_written);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
